/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the congestion window RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hw/rtl/tcw_pkg.sv */
// Package for the congestion window block: widths, reset values, codes and
// the command and status structs between controller and datapath. No dependencies.
package tcw_pkg;

  // Default window width; the top level parameter takes its default from here.
  localparam int WINDOW_BITS_DEF = 24;

  // Fixed field widths.
  localparam int SEG_W      = 16;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_W      = 24;
  localparam int CNT_W      = 32;
  localparam int MODE_W     = 2;

  // Divider: dividend is the squared segment size.
  localparam int DIV_W      = 2 * SEG_W;
  localparam int DIV_STEPS  = DIV_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Reset values of the configuration registers.
  localparam logic [SEG_W-1:0]      RESET_SEGMENT   = 16'd1460;
  localparam logic [CFG_DATA_W-1:0] RESET_THRESHOLD = 24'd64000;

  // Configuration register indexes.
  localparam logic CFG_SEGMENT_SIZE      = 1'b0;
  localparam logic CFG_INITIAL_THRESHOLD = 1'b1;

  // Branch codes reported in the result.
  localparam logic [MODE_W-1:0] MODE_TIMEOUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SLOW      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AVOIDANCE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the request and start the divider
    logic div_step;  // one restoring division step
    logic commit;    // update the state and load the result register
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_div; // the pending request is an avoidance step on a nonzero window
    logic div_last;  // the current division step is the final one
  } tcw_status_t;

endpackage

/* hw/rtl/tcw_if.sv */
// Valid/ready channel interfaces for the request and result streams.
// Depends on tcw_pkg for the field widths.
interface tcw_in_if import tcw_pkg::*; ();
  logic valid;
  logic ready;
  logic is_timeout;

  modport source (output valid, output is_timeout, input ready);
  modport sink   (input valid, input is_timeout, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  window;
  logic [OUT_W-1:0]  threshold;
  logic [MODE_W-1:0] mode;
  logic [CNT_W-1:0]  slow_start_count;
  logic [CNT_W-1:0]  avoidance_count;

  modport source (output valid, output window, output threshold, output mode,
                  output slow_start_count, output avoidance_count, input ready);
  modport sink   (input valid, input window, input threshold, input mode,
                  input slow_start_count, input avoidance_count, output ready);
endinterface

/* hw/rtl/tcw_ctrl.sv */
// Controller state machine: sequences capture, division and commit, and owns
// the request ready and result valid flags. Depends on tcw_pkg.
module tcw_ctrl import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  tcw_status_t status,
  output tcw_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.div_step = 1'b0;
    cmd.commit   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = status.needs_div ? ST_DIV : ST_COMMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result register is full after a commit until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/tcw_dp.sv */
// Datapath: configuration registers, window and threshold state, step counters,
// the bit-serial divider and the result register. Depends on tcw_pkg.
module tcw_dp import tcw_pkg::*; #(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_is_timeout,
  input  tcw_cmd_t              cmd,
  output tcw_status_t           status,
  output logic [OUT_W-1:0]      out_window,
  output logic [OUT_W-1:0]      out_threshold,
  output logic [MODE_W-1:0]     out_mode,
  output logic [CNT_W-1:0]      out_slow_start_count,
  output logic [CNT_W-1:0]      out_avoidance_count
);

  localparam int SUM_W = DIV_W + 1;

  logic [SEG_W-1:0]       seg_r;
  logic [WINDOW_BITS-1:0] win_r, win_nxt;
  logic [WINDOW_BITS-1:0] thr_r, thr_nxt;
  logic [CNT_W-1:0]       ss_cnt_r, ss_cnt_nxt;
  logic [CNT_W-1:0]       ca_cnt_r, ca_cnt_nxt;
  logic [MODE_W-1:0]      mode_r, mode_nxt;

  logic [DIV_W-1:0]       quo_r;
  logic [WINDOW_BITS-1:0] rem_r;
  logic [DIV_CNT_W-1:0]   cnt_r;

  logic [OUT_W-1:0]       res_win_r;
  logic [OUT_W-1:0]       res_thr_r;
  logic [MODE_W-1:0]      res_mode_r;
  logic [CNT_W-1:0]       res_ss_r;
  logic [CNT_W-1:0]       res_ca_r;

  logic [DIV_W-1:0]       seg_sq;
  logic [WINDOW_BITS:0]   rem_sh;
  logic [WINDOW_BITS:0]   rem_diff;
  logic                   rem_ge;
  logic [DIV_W-1:0]       inc;
  logic [SUM_W-1:0]       sum;
  logic [WINDOW_BITS-1:0] win_max;
  logic                   win_zero;

  assign win_max  = '1;
  assign win_zero = (win_r == '0);

  // Branch chosen by the incoming request.
  always_comb begin
    if (in_is_timeout) begin
      mode_nxt = MODE_TIMEOUT;
    end else if (win_r < thr_r) begin
      mode_nxt = MODE_SLOW;
    end else begin
      mode_nxt = MODE_AVOIDANCE;
    end
  end

  assign status.needs_div = (mode_nxt == MODE_AVOIDANCE) && !win_zero;
  assign status.div_last  = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // Squared segment size, registered into the divider at capture.
  assign seg_sq = {{SEG_W{1'b0}}, seg_r} * {{SEG_W{1'b0}}, seg_r};

  // One restoring step: shift in a dividend bit, subtract the window if it fits.
  assign rem_sh   = {rem_r, quo_r[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, win_r};
  assign rem_ge   = (rem_sh >= {1'b0, win_r});

  // Saturating window update.
  assign inc = win_zero ? DIV_W'(seg_r) : quo_r;
  assign sum = SUM_W'(win_r) + SUM_W'(inc);

  always_comb begin
    win_nxt    = win_r;
    thr_nxt    = thr_r;
    ss_cnt_nxt = ss_cnt_r;
    ca_cnt_nxt = ca_cnt_r;
    case (mode_r)
      MODE_TIMEOUT: begin
        thr_nxt    = win_r >> 1;
        win_nxt    = WINDOW_BITS'(seg_r);
        ss_cnt_nxt = ss_cnt_r + 1'b1;
      end
      MODE_SLOW: begin
        win_nxt    = (SUM_W'(win_r) + SUM_W'(seg_r) > SUM_W'(win_max)) ?
                     win_max : WINDOW_BITS'(SUM_W'(win_r) + SUM_W'(seg_r));
        ss_cnt_nxt = ss_cnt_r + 1'b1;
      end
      MODE_AVOIDANCE: begin
        win_nxt    = (sum > SUM_W'(win_max)) ? win_max : WINDOW_BITS'(sum);
        ca_cnt_nxt = ca_cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Architectural state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r    <= RESET_SEGMENT;
      win_r    <= '0;
      thr_r    <= WINDOW_BITS'(RESET_THRESHOLD);
      ss_cnt_r <= '0;
      ca_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SEGMENT_SIZE: begin
            seg_r <= cfg_wdata[SEG_W-1:0];
          end
          CFG_INITIAL_THRESHOLD: begin
            thr_r <= WINDOW_BITS'(cfg_wdata);
          end
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        win_r    <= win_nxt;
        thr_r    <= thr_nxt;
        ss_cnt_r <= ss_cnt_nxt;
        ca_cnt_r <= ca_cnt_nxt;
      end
    end
  end

  // Request latch and divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.capture) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_nxt;
      quo_r  <= seg_sq;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DIV_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_diff[WINDOW_BITS-1:0] : rem_sh[WINDOW_BITS-1:0];
    end
  end

  // Result register, loaded at commit with the updated state.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_win_r  <= OUT_W'(win_nxt);
      res_thr_r  <= OUT_W'(thr_nxt);
      res_mode_r <= mode_r;
      res_ss_r   <= ss_cnt_nxt;
      res_ca_r   <= ca_cnt_nxt;
    end
  end

  assign out_window           = res_win_r;
  assign out_threshold        = res_thr_r;
  assign out_mode             = res_mode_r;
  assign out_slow_start_count = res_ss_r;
  assign out_avoidance_count  = res_ca_r;

endmodule

/* hw/rtl/tcp_congestion_window_core.sv */
// TCP Tahoe congestion window core: top level joining controller and datapath.
// Depends on tcw_pkg, tcw_if.sv, tcw_ctrl, tcw_dp and assert_macros.svh.
//
// Usage: each request on in_req carries one event, is_timeout high for a
// retransmission timeout and low for an acknowledgement. Every request
// yields exactly one result on out_res: the new window and threshold, the
// branch taken and the two step counters.
// Sequence: a timeout, a slow start step or an avoidance step on a zero
// window goes from acceptance to the commit state; an avoidance step on a
// nonzero window first runs the bit-serial divider (segment squared over
// window), one quotient bit per cycle. A request commits once the result
// register is free and shows on out_res in the cycle after its commit. One
// request is in work at a time: no new request is taken before it commits.
// The result sits in an output register, so the next request is taken while
// an earlier result waits; if the receiver holds ready low, the following
// request waits at its commit until the result register is free.
// Reset (synchronous, active low) sets the segment size to 1460, the
// threshold to 64000 and clears the window and counters. The user must write
// configuration via cfg_wr_en/cfg_index/cfg_wdata while idle; not enforced.
module tcp_congestion_window_core import tcw_pkg::*; #(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tcw_in_if.sink                in_req,
  tcw_out_if.source             out_res
);

`include "assert_macros.svh"

  tcw_cmd_t    cmd;
  tcw_status_t status;
  logic        in_ready;
  logic        out_valid;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_dp #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_is_timeout        (in_req.is_timeout),
    .cmd                  (cmd),
    .status               (status),
    .out_window           (out_res.window),
    .out_threshold        (out_res.threshold),
    .out_mode             (out_res.mode),
    .out_slow_start_count (out_res.slow_start_count),
    .out_avoidance_count  (out_res.avoidance_count)
  );

  assign in_req.ready  = in_ready;
  assign out_res.valid = out_valid;

  // An accepted request leaves the core busy in the cycle after it is accepted.
  `ASSERT_NEXT(a_busy_after_accept, in_req.valid && in_ready, !in_ready, "ready after accept")

  // A commit never overwrites a result the receiver has not taken.
  `ASSERT_ALWAYS(a_commit_slot_free, !cmd.commit || !out_valid || out_res.ready, "result lost")

  // Capture, division and commit are mutually exclusive.
  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.capture, cmd.div_step, cmd.commit}), "cmd overlap")

  // The last division step is always followed by a commit attempt, not another step.
  `ASSERT_NEXT(a_div_ends, cmd.div_step && status.div_last, !cmd.div_step, "divider overrun")

endmodule
